/* rtl/tfn_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared constants and types for the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int COORD_BITS_DEF       = 24;
    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int OUT_BITS             = 16;

    typedef struct packed {
        logic       valid;
        logic       degen;
        logic [2:0] sign;
    } tfn_ctrl_t;

endpackage
`default_nettype wire

/* rtl/tfn_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_front
// Edge vectors, cross product, component squares and squared length.
// ----------------------------------------------------------------------------
module tfn_front #(
    parameter int COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF,
    parameter int EB = COORD_BITS + 1,
    parameter int NB = 2 * EB + 1,
    parameter int SQ = 2 * NB,
    parameter int W  = SQ + 2 * NORMAL_FRAC_BITS + 4
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [2:0][COORD_BITS-1:0]  pa,
    input  wire logic [2:0][COORD_BITS-1:0]  pb,
    input  wire logic [2:0][COORD_BITS-1:0]  pc,
    output tfn_pkg::tfn_ctrl_t               ctrl_out,
    output logic      [W-1:0]                l2_out,
    output logic      [2:0][W-1:0]           r_out
);
    import tfn_pkg::*;

    localparam int PB = 2 * EB;
    localparam int H  = (NB + 1) / 2;
    localparam int HB = NB - H;
    localparam int F  = NORMAL_FRAC_BITS;

    logic [5:0] v_reg;
    logic signed [2:0][EB-1:0] e1_reg, e2_reg;
    logic signed [5:0][PB-1:0] p_reg;
    logic [2:0][NB-1:0] mag_reg;
    logic [2:0] s3_reg, s4_reg, s5_reg, s6_reg;
    logic z3_reg, z4_reg, z5_reg, z6_reg;
    logic [2:0][2*HB-1:0] hh_reg;
    logic [2:0][NB-1:0]   hl_reg;
    logic [2:0][2*H-1:0]  ll_reg;
    logic [2:0][SQ-1:0]   sq_reg;
    logic [W-1:0]         l2_reg;
    logic [2:0][W-1:0]    r_reg;
    logic signed [2:0][NB-1:0] n_next;
    logic [2:0][SQ-1:0]   sq_next;

    always_comb begin
        n_next[0] = {p_reg[0][PB-1], p_reg[0]} - {p_reg[1][PB-1], p_reg[1]};
        n_next[1] = {p_reg[2][PB-1], p_reg[2]} - {p_reg[3][PB-1], p_reg[3]};
        n_next[2] = {p_reg[4][PB-1], p_reg[4]} - {p_reg[5][PB-1], p_reg[5]};
        for (int i = 0; i < 3; i++) begin
            sq_next[i] = (SQ'(hh_reg[i]) << (2 * H)) + (SQ'(hl_reg[i]) << (H + 1))
                       + SQ'(ll_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                e1_reg[i] <= {pb[i][COORD_BITS-1], pb[i]} - {pa[i][COORD_BITS-1], pa[i]};
                e2_reg[i] <= {pc[i][COORD_BITS-1], pc[i]} - {pa[i][COORD_BITS-1], pa[i]};
            end
            p_reg[0] <= $signed(e1_reg[1]) * $signed(e2_reg[2]);
            p_reg[1] <= $signed(e1_reg[2]) * $signed(e2_reg[1]);
            p_reg[2] <= $signed(e1_reg[2]) * $signed(e2_reg[0]);
            p_reg[3] <= $signed(e1_reg[0]) * $signed(e2_reg[2]);
            p_reg[4] <= $signed(e1_reg[0]) * $signed(e2_reg[1]);
            p_reg[5] <= $signed(e1_reg[1]) * $signed(e2_reg[0]);
            for (int i = 0; i < 3; i++) begin
                s3_reg[i]  <= n_next[i][NB-1];
                mag_reg[i] <= n_next[i][NB-1] ? ('0 - n_next[i]) : n_next[i];
            end
            z3_reg <= (n_next[0] == '0) && (n_next[1] == '0) && (n_next[2] == '0);
            for (int i = 0; i < 3; i++) begin
                hh_reg[i] <= mag_reg[i][NB-1:H] * mag_reg[i][NB-1:H];
                hl_reg[i] <= mag_reg[i][NB-1:H] * mag_reg[i][H-1:0];
                ll_reg[i] <= mag_reg[i][H-1:0] * mag_reg[i][H-1:0];
            end
            s4_reg <= s3_reg;
            z4_reg <= z3_reg;
            sq_reg <= sq_next;
            s5_reg <= s4_reg;
            z5_reg <= z4_reg;
            l2_reg <= W'(sq_reg[0]) + W'(sq_reg[1]) + W'(sq_reg[2]);
            for (int i = 0; i < 3; i++) begin
                r_reg[i] <= W'(sq_reg[i]) << (2 * F);
            end
            s6_reg <= s5_reg;
            z6_reg <= z5_reg;
        end
    end

    assign ctrl_out = '{valid: v_reg[5], degen: z6_reg, sign: s6_reg};
    assign l2_out   = l2_reg;
    assign r_out    = r_reg;

endmodule
`default_nettype wire

/* rtl/tfn_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_cell
// One quotient bit of the three unit normal components.
// ----------------------------------------------------------------------------
module tfn_cell #(
    parameter int W   = 140,
    parameter int QB  = 15,
    parameter int BIT = 0
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire tfn_pkg::tfn_ctrl_t   ctrl_in,
    input  wire logic [W-1:0]         l2_in,
    input  wire logic [2:0][W-1:0]    r_in,
    input  wire logic [2:0][W-1:0]    d_in,
    input  wire logic [2:0][QB-1:0]   q_in,
    output tfn_pkg::tfn_ctrl_t        ctrl_out,
    output logic      [W-1:0]         l2_out,
    output logic      [2:0][W-1:0]    r_out,
    output logic      [2:0][W-1:0]    d_out,
    output logic      [2:0][QB-1:0]   q_out
);
    import tfn_pkg::*;

    logic               valid_reg;
    tfn_ctrl_t          ctrl_reg;
    logic [W-1:0]       l2_reg;
    logic [2:0][W-1:0]  r_reg, d_reg, r_next, d_next, cand;
    logic [2:0][QB-1:0] q_reg, q_next;

    // take bit when (2^(b+1) q + 2^2b) L^2 fits in the remainder
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cand[i] = (d_in[i] << (BIT + 1)) + (l2_in << (2 * BIT));
            if (cand[i] <= r_in[i]) begin
                r_next[i] = r_in[i] - cand[i];
                d_next[i] = d_in[i] + (l2_in << BIT);
                q_next[i] = q_in[i] | (QB'(1) << BIT);
            end else begin
                r_next[i] = r_in[i];
                d_next[i] = d_in[i];
                q_next[i] = q_in[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctrl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctrl_reg <= ctrl_in;
            l2_reg   <= l2_in;
            r_reg    <= r_next;
            d_reg    <= d_next;
            q_reg    <= q_next;
        end
    end

    assign ctrl_out = '{valid: valid_reg, degen: ctrl_reg.degen, sign: ctrl_reg.sign};
    assign l2_out   = l2_reg;
    assign r_out    = r_reg;
    assign d_out    = d_reg;
    assign q_out    = q_reg;

endmodule
`default_nettype wire

/* rtl/triangle_face_normal.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit normal of a triangle face from its three corners, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  direction  words
//  s_       in         corner a, b, c (x, y, z), signed fixed point
//  m_       out        unit normal x, y, z (Q1.14) and degenerate flag
//
//  one face word per cycle while m_ready does not hold the output; the path runs
//  through six front stages, one cell per quotient bit and the output register
//  synchronous active-low reset clears the valid bits of every stage
//  the whole pipeline holds while an output word waits on m_ready
// ----------------------------------------------------------------------------
module triangle_face_normal #(
    parameter int COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [COORD_BITS-1:0]         s_corner_a_x,
    input  wire logic [COORD_BITS-1:0]         s_corner_a_y,
    input  wire logic [COORD_BITS-1:0]         s_corner_a_z,
    input  wire logic [COORD_BITS-1:0]         s_corner_b_x,
    input  wire logic [COORD_BITS-1:0]         s_corner_b_y,
    input  wire logic [COORD_BITS-1:0]         s_corner_b_z,
    input  wire logic [COORD_BITS-1:0]         s_corner_c_x,
    input  wire logic [COORD_BITS-1:0]         s_corner_c_y,
    input  wire logic [COORD_BITS-1:0]         s_corner_c_z,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [tfn_pkg::OUT_BITS-1:0]  m_unit_normal_x,
    output logic      [tfn_pkg::OUT_BITS-1:0]  m_unit_normal_y,
    output logic      [tfn_pkg::OUT_BITS-1:0]  m_unit_normal_z,
    output logic                               m_degenerate_face
);
    import tfn_pkg::*;

    localparam int F  = NORMAL_FRAC_BITS;
    localparam int EB = COORD_BITS + 1;
    localparam int NB = 2 * EB + 1;
    localparam int SQ = 2 * NB;
    localparam int W  = SQ + 2 * F + 4;
    localparam int QB = F + 1;
    localparam int NC = F + 1;

    logic en;
    tfn_ctrl_t          ctrl_c [NC+1];
    logic [W-1:0]       l2_c   [NC+1];
    logic [2:0][W-1:0]  r_c    [NC+1];
    logic [2:0][W-1:0]  d_c    [NC+1];
    logic [2:0][QB-1:0] q_c    [NC+1];

    logic                             m_valid_reg, m_degen_reg;
    logic [2:0][OUT_BITS-1:0]         m_n_reg, m_n_next;
    logic [OUT_BITS-1:0]              qx;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    tfn_front #(
        .COORD_BITS      (COORD_BITS),
        .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS),
        .EB              (EB),
        .NB              (NB),
        .SQ              (SQ),
        .W               (W)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_valid(s_valid),
        .pa      ({s_corner_a_z, s_corner_a_y, s_corner_a_x}),
        .pb      ({s_corner_b_z, s_corner_b_y, s_corner_b_x}),
        .pc      ({s_corner_c_z, s_corner_c_y, s_corner_c_x}),
        .ctrl_out(ctrl_c[0]),
        .l2_out  (l2_c[0]),
        .r_out   (r_c[0])
    );

    assign d_c[0] = '0;
    assign q_c[0] = '0;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        tfn_cell #(
            .W  (W),
            .QB (QB),
            .BIT(F - k)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctrl_in (ctrl_c[k]),
            .l2_in   (l2_c[k]),
            .r_in    (r_c[k]),
            .d_in    (d_c[k]),
            .q_in    (q_c[k]),
            .ctrl_out(ctrl_c[k+1]),
            .l2_out  (l2_c[k+1]),
            .r_out   (r_c[k+1]),
            .d_out   (d_c[k+1]),
            .q_out   (q_c[k+1])
        );
    end

    always_comb begin
        qx = '0;
        for (int i = 0; i < 3; i++) begin
            qx = OUT_BITS'(q_c[NC][i]);
            if (ctrl_c[NC].degen) begin
                m_n_next[i] = '0;
            end else if (ctrl_c[NC].sign[i]) begin
                m_n_next[i] = '0 - qx;
            end else begin
                m_n_next[i] = qx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= ctrl_c[NC].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_n_reg     <= m_n_next;
            m_degen_reg <= ctrl_c[NC].degen;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_unit_normal_x   = m_n_reg[0];
    assign m_unit_normal_y   = m_n_reg[1];
    assign m_unit_normal_z   = m_n_reg[2];
    assign m_degenerate_face = m_degen_reg;

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate_face |->
            m_unit_normal_x == '0 && m_unit_normal_y == '0 && m_unit_normal_z == '0)
        else $error("degenerate word with nonzero normal");

    a_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_c[NC].valid && !ctrl_c[NC].degen |->
            q_c[NC][0] <= (QB'(1) << F) && q_c[NC][1] <= (QB'(1) << F)
            && q_c[NC][2] <= (QB'(1) << F))
        else $error("quotient above one");

    a_hold_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(ctrl_c[NC].valid) && $stable(ctrl_c[0].valid))
        else $error("pipeline moved during output stall");

endmodule
`default_nettype wire

/* tb/sv/triangle_face_normal_chk.sv */
// ----------------------------------------------------------------------------
// triangle_face_normal_chk
// Watches both channels of the face normal block. Each accepted face word is
// turned into its expected unit normal by an exact integer model of the block
// and queued. Each result word is compared field by field with the oldest
// queued normal. Mismatches and unexpected result words are counted.
// ----------------------------------------------------------------------------
module triangle_face_normal_chk (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire logic [8:0][23:0]      s_face,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire logic [15:0]           m_unit_normal_x,
    input  wire logic [15:0]           m_unit_normal_y,
    input  wire logic [15:0]           m_unit_normal_z,
    input  wire logic                  m_degenerate_face,
    output int                         mismatch_count,
    output int                         normals_pending
);

    localparam int FRAC = tfn_pkg::NORMAL_FRAC_BITS_DEF;

    typedef struct packed {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        degen;
    } normal_t;

    normal_t normal_q[$];

    // floor(|c| * 2^FRAC / L), saturated at one, carrying the sign of c
    function automatic logic [15:0] unit_part(input logic signed [63:0] c,
                                              input logic [159:0] len_sq);
        logic [63:0]  mag;
        logic [159:0] rhs;
        logic [15:0]  q;
        logic [15:0]  t;
        mag = c[63] ? -c : c;
        rhs = (160'(mag) * 160'(mag)) << (2 * FRAC);
        q = '0;
        for (int b = FRAC; b >= 0; b--) begin
            t = q | (16'd1 << b);
            if (t <= (16'd1 << FRAC) && 160'(t) * 160'(t) * len_sq <= rhs)
                q = t;
        end
        return c[63] ? -q : q;
    endfunction

    function automatic normal_t face_normal(input logic [8:0][23:0] f);
        logic signed [63:0] p [9];
        logic signed [63:0] e1x, e1y, e1z, e2x, e2y, e2z, cx, cy, cz;
        logic [159:0]       len_sq;
        normal_t            r;
        for (int i = 0; i < 9; i++)
            p[i] = {{40{f[i][23]}}, f[i]};
        e1x = p[3] - p[0];
        e1y = p[4] - p[1];
        e1z = p[5] - p[2];
        e2x = p[6] - p[0];
        e2y = p[7] - p[1];
        e2z = p[8] - p[2];
        cx = e1y * e2z - e1z * e2y;
        cy = e1z * e2x - e1x * e2z;
        cz = e1x * e2y - e1y * e2x;
        len_sq = 160'(cx[63] ? -cx : cx) * 160'(cx[63] ? -cx : cx)
               + 160'(cy[63] ? -cy : cy) * 160'(cy[63] ? -cy : cy)
               + 160'(cz[63] ? -cz : cz) * 160'(cz[63] ? -cz : cz);
        if (len_sq == 0) begin
            r = '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
        end else begin
            r.nx = unit_part(cx, len_sq);
            r.ny = unit_part(cy, len_sq);
            r.nz = unit_part(cz, len_sq);
            r.degen = 1'b0;
        end
        return r;
    endfunction

    initial begin
        mismatch_count = 0;
        normals_pending = 0;
    end

    always @(posedge aclk) begin
        normal_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                normal_q = {normal_q, face_normal(s_face)};
            if (m_valid && m_ready) begin
                if (normal_q.size() == 0) begin
                    $error("result word with no face outstanding");
                    mismatch_count++;
                end else begin
                    want = normal_q.pop_front();
                    if (m_unit_normal_x !== want.nx) begin
                        $error("unit_normal_x expected %0d got %0d",
                               $signed(want.nx), $signed(m_unit_normal_x));
                        mismatch_count++;
                    end
                    if (m_unit_normal_y !== want.ny) begin
                        $error("unit_normal_y expected %0d got %0d",
                               $signed(want.ny), $signed(m_unit_normal_y));
                        mismatch_count++;
                    end
                    if (m_unit_normal_z !== want.nz) begin
                        $error("unit_normal_z expected %0d got %0d",
                               $signed(want.nz), $signed(m_unit_normal_z));
                        mismatch_count++;
                    end
                    if (m_degenerate_face !== want.degen) begin
                        $error("degenerate_face expected %0d got %0d",
                               want.degen, m_degenerate_face);
                        mismatch_count++;
                    end
                end
            end
            normals_pending <= normal_q.size();
        end
    end

endmodule

/* tb/sv/triangle_face_normal_tb.sv */
// ----------------------------------------------------------------------------
// triangle_face_normal_tb
// Drives directed and random faces into the face normal block under varying
// back-pressure on both sides; a checker beside the block predicts and
// compares every result word. Gives the final verdict.
// ----------------------------------------------------------------------------
module triangle_face_normal_tb;

    localparam int STALL_LIMIT = 4000;
    localparam int CMAX = 8388607;
    localparam int CMIN = -8388608;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [8:0][23:0] s_face = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [15:0]      m_unit_normal_x;
    logic [15:0]      m_unit_normal_y;
    logic [15:0]      m_unit_normal_z;
    logic             m_degenerate_face;
    int               mismatch_count;
    int               normals_pending;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               stall_cycles = 0;

    always #4 aclk = ~aclk;

    triangle_face_normal dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_corner_a_x      (s_face[0]),
        .s_corner_a_y      (s_face[1]),
        .s_corner_a_z      (s_face[2]),
        .s_corner_b_x      (s_face[3]),
        .s_corner_b_y      (s_face[4]),
        .s_corner_b_z      (s_face[5]),
        .s_corner_c_x      (s_face[6]),
        .s_corner_c_y      (s_face[7]),
        .s_corner_c_z      (s_face[8]),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_unit_normal_x   (m_unit_normal_x),
        .m_unit_normal_y   (m_unit_normal_y),
        .m_unit_normal_z   (m_unit_normal_z),
        .m_degenerate_face (m_degenerate_face)
    );

    triangle_face_normal_chk chk (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_face            (s_face),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_unit_normal_x   (m_unit_normal_x),
        .m_unit_normal_y   (m_unit_normal_y),
        .m_unit_normal_z   (m_unit_normal_z),
        .m_degenerate_face (m_degenerate_face),
        .mismatch_count    (mismatch_count),
        .normals_pending   (normals_pending)
    );

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_face(input int ax, ay, az, bx, by, bz, cx, cy, cz);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_face <= {24'(cz), 24'(cy), 24'(cx), 24'(bz), 24'(by), 24'(bx),
                   24'(az), 24'(ay), 24'(ax)};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic int rand_coord(input int span);
        return $urandom_range(2 * span) - span;
    endfunction

    task automatic send_random_face();
        int ax, ay, az, bx, by, bz, cx, cy, cz, k, pick;
        pick = $urandom_range(99);
        ax = rand_coord(CMAX); ay = rand_coord(CMAX); az = rand_coord(CMAX);
        bx = rand_coord(CMAX); by = rand_coord(CMAX); bz = rand_coord(CMAX);
        cx = rand_coord(CMAX); cy = rand_coord(CMAX); cz = rand_coord(CMAX);
        if (pick < 45) begin
            ax = $urandom; ay = $urandom; az = $urandom;
            bx = $urandom; by = $urandom; bz = $urandom;
            cx = $urandom; cy = $urandom; cz = $urandom;
        end else if (pick < 70) begin
            bx = ax + rand_coord(4096); by = ay + rand_coord(4096);
            bz = az + rand_coord(4096); cx = ax + rand_coord(4096);
            cy = ay + rand_coord(4096); cz = az + rand_coord(4096);
        end else if (pick < 82) begin
            // collinear corners
            ax = rand_coord(1 << 20); ay = rand_coord(1 << 20); az = rand_coord(1 << 20);
            bx = ax + rand_coord(1 << 20); by = ay + rand_coord(1 << 20);
            bz = az + rand_coord(1 << 20);
            k = rand_coord(3);
            cx = ax + k * (bx - ax); cy = ay + k * (by - ay); cz = az + k * (bz - az);
        end else if (pick < 94) begin
            // face in an axis plane
            case ($urandom_range(2))
                0: begin bx = ax; cx = ax; end
                1: begin by = ay; cy = ay; end
                default: begin bz = az; cz = az; end
            endcase
        end else begin
            bx = ax + rand_coord(3); by = ay + rand_coord(3); bz = az + rand_coord(3);
            cx = ax + rand_coord(3); cy = ay + rand_coord(3); cz = az + rand_coord(3);
        end
        send_face(ax, ay, az, bx, by, bz, cx, cy, cz);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 15;
        recv_idle_pct = 52;

        send_face(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_face(5, 6, 7, 5, 6, 7, 9, 9, 9);
        send_face(0, 0, 0, 4096, 4096, 4096, 8192, 8192, 8192);
        send_face(0, 0, 0, 4096, 0, 0, 0, 4096, 0);
        send_face(0, 0, 0, 0, 4096, 0, 4096, 0, 0);
        send_face(0, 0, 0, 0, 4096, 0, 0, 0, 4096);
        send_face(0, 0, 0, 0, 0, 4096, 0, 4096, 0);
        send_face(0, 0, 0, 0, 0, 4096, 4096, 0, 0);
        send_face(0, 0, 0, 4096, 0, 0, 0, 0, 4096);
        send_face(0, 0, 0, 4096, 0, 0, 0, 4096, 4096);
        send_face(0, 0, 0, 1, 0, 0, 1, 1, 1);
        send_face(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN);
        send_face(CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX);
        send_face(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMAX);
        send_face(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN);
        send_face(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
        send_face(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        send_face(CMIN, 0, CMAX, CMAX, CMIN, 0, 0, CMAX, CMIN);
        send_face(-1, -1, -1, 0, -1, -1, -1, 0, -1);
        send_face(0, 0, 0, 1, 1, 0, 1, 0, 1);
        send_face(0, 0, 0, CMAX, 1, 0, 1, CMAX, 0);
        send_face(0, 0, 0, 3, 1, 1, 1, 3, 1);

        for (int i = 0; i < 360; i++) send_random_face();
        send_idle_pct = 52;
        recv_idle_pct = 15;
        for (int i = 0; i < 360; i++) send_random_face();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 360; i++) send_random_face();
        s_valid <= 1'b0;

        do @(posedge aclk); while (normals_pending != 0 || m_valid);
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && normals_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
